// ----- rtl/u2u_pkg.sv -----
// Package for the UTF-8 to UCS-2 decoder: widths, character constants and
// the result descriptor passed from the decode stage to the output stage.
// No dependencies.
`default_nettype none

package u2u_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned UnitW  = 16;
	localparam int unsigned CountW = 16;

	localparam logic [UnitW-1:0]  QMark        = 16'h003F;
	localparam logic [CountW-1:0] MaxUnitsRst  = 16'd255;
	localparam logic [UnitW-1:0]  MinTwoByte   = 16'h0080;
	localparam logic [UnitW-1:0]  MinThreeByte = 16'h0800;
	localparam logic [UnitW-1:0]  SurrLo       = 16'hD800;
	localparam logic [UnitW-1:0]  SurrHi       = 16'hDFFF;

	// results caused by one byte: qmark_n flush '?' units, then optionally one final result
	typedef struct packed {
		logic [1:0]        qmark_n;
		logic              has_last;
		logic [UnitW-1:0]  unit;
		logic              term;
		logic [CountW-1:0] count;
	} run_t;

endpackage

`default_nettype wire

// ----- rtl/u2u_decode.sv -----
// Decode stage: holds the pending-sequence state and the per-string unit
// count, and turns one byte into a run descriptor. Depends on u2u_pkg.
`default_nettype none

module u2u_decode (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [u2u_pkg::ByteW-1:0]  text_byte,
	input  wire logic [u2u_pkg::CountW-1:0] max_units,
	output u2u_pkg::run_t                   run
);
	import u2u_pkg::*;

	logic [2:0]        expected_len_q;
	logic [1:0]        held_count_q;
	logic [UnitW-1:0]  partial_point_q;
	logic [CountW-1:0] units_written_q;

	logic [2:0]        expected_len_d;
	logic [1:0]        held_count_d;
	logic [UnitW-1:0]  partial_point_d;
	logic [CountW-1:0] units_written_d;

	logic              is_cont;
	logic [1:0]        got;
	logic [UnitW-1:0]  cp;
	logic [1:0]        flush_n;
	logic              want_unit;
	logic [UnitW-1:0]  unit_val;
	logic              term;
	logic [CountW-1:0] avail;
	logic [1:0]        qmark_n;
	logic              fin;
	logic [2:0]        emitted;

	always_comb begin
		expected_len_d  = expected_len_q;
		held_count_d    = held_count_q;
		partial_point_d = partial_point_q;
		flush_n         = 2'd0;
		want_unit       = 1'b0;
		unit_val        = QMark;
		term            = 1'b0;
		is_cont         = (expected_len_q != 3'd0) && (text_byte[7:6] == 2'b10);
		got             = held_count_q + 2'd1;
		cp              = partial_point_q | {10'b0, text_byte[5:0]};

		if (is_cont) begin
			if ({1'b0, got} + 3'd1 < expected_len_q) begin
				if (expected_len_q == 3'd3)
					partial_point_d = partial_point_q | {4'b0, text_byte[5:0], 6'b0};
				held_count_d = got;
			end else begin
				want_unit = 1'b1;
				case (expected_len_q)
					3'd2: unit_val = (cp < MinTwoByte) ? QMark : cp;
					3'd3: unit_val = (cp < MinThreeByte || (cp >= SurrLo && cp <= SurrHi))
						? QMark : cp;
					default: unit_val = QMark;
				endcase
				expected_len_d  = 3'd0;
				held_count_d    = 2'd0;
				partial_point_d = '0;
			end
		end else begin
			// a pending sequence is broken: '?' for the lead and each held byte
			flush_n         = (expected_len_q != 3'd0) ? got : 2'd0;
			expected_len_d  = 3'd0;
			held_count_d    = 2'd0;
			partial_point_d = '0;
			if (text_byte == 8'h00) begin
				term = 1'b1;
			end else if (text_byte[7] == 1'b0) begin
				want_unit = 1'b1;
				unit_val  = {8'b0, text_byte};
			end else if (text_byte[7:5] == 3'b110) begin
				expected_len_d  = 3'd2;
				partial_point_d = {5'b0, text_byte[4:0], 6'b0};
			end else if (text_byte[7:4] == 4'b1110) begin
				expected_len_d  = 3'd3;
				partial_point_d = {text_byte[3:0], 12'b0};
			end else if (text_byte[7:3] == 5'b11110) begin
				expected_len_d = 3'd4;
			end else begin
				want_unit = 1'b1;
			end
		end

		// limit on units per string; the terminator is never dropped
		avail   = (max_units > units_written_q) ? (max_units - units_written_q) : '0;
		qmark_n = ({14'b0, flush_n} <= avail) ? flush_n : avail[1:0];
		fin     = want_unit && ({14'b0, flush_n} < avail);
		emitted = {1'b0, qmark_n} + {2'b0, fin};

		units_written_d = term ? '0 : units_written_q + {13'b0, emitted};

		run.qmark_n  = qmark_n;
		run.has_last = fin || term;
		run.unit     = term ? '0 : unit_val;
		run.term     = term;
		run.count    = term ? units_written_q + {14'b0, qmark_n} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_len_q  <= 3'd0;
			held_count_q    <= 2'd0;
			partial_point_q <= '0;
			units_written_q <= '0;
		end else if (step) begin
			expected_len_q  <= expected_len_d;
			held_count_q    <= held_count_d;
			partial_point_q <= partial_point_d;
			units_written_q <= units_written_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/utf8_to_ucs2_decoder.sv -----
// Path: byte_s1, then the output run register, to the first result on the master side.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready
// is high; a byte giving several results holds the single output run register until all are taken.
// Reset: asynchronous, active low; clears the pending sequence, unit count and
// valids, and sets max_units to 255.
`default_nettype none

module utf8_to_ucs2_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,    // max_units
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,     // [7:0] text_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,     // [15:0] code_unit, [31:16] unit_count
	output logic             m_tuser,     // [0] is_terminator
	output logic             m_tlast      // last_of_run
);
	import u2u_pkg::*;

	logic [CountW-1:0] max_units_q;
	logic              byte_vld_s1;
	logic [ByteW-1:0]  byte_s1;
	run_t              dec_run;
	run_t              run_q;
	logic [1:0]        qmark_left_q;
	logic              last_pend_q;
	logic              run_done;
	logic              load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_units_q <= MaxUnitsRst;
		else if (cfg_valid)
			max_units_q <= cfg_data;
	end

	assign m_tvalid = (qmark_left_q != 2'd0) || last_pend_q;
	assign run_done = m_tvalid && m_tready &&
		(qmark_left_q == 2'd0 || (qmark_left_q == 2'd1 && !last_pend_q));
	assign load     = byte_vld_s1 && (!m_tvalid || run_done);
	assign s_tready = !byte_vld_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_vld_s1 <= 1'b0;
		else if (s_tready)
			byte_vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	u2u_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (load),
		.text_byte (byte_s1),
		.max_units (max_units_q),
		.run       (dec_run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qmark_left_q <= 2'd0;
			last_pend_q  <= 1'b0;
		end else if (load) begin
			qmark_left_q <= dec_run.qmark_n;
			last_pend_q  <= dec_run.has_last;
		end else if (m_tvalid && m_tready) begin
			if (qmark_left_q != 2'd0)
				qmark_left_q <= qmark_left_q - 2'd1;
			else
				last_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			run_q <= dec_run;
	end

	// flush '?' items come first, the final result of the run last
	always_comb begin
		if (qmark_left_q != 2'd0) begin
			m_tdata = {16'b0, QMark};
			m_tuser = 1'b0;
			m_tlast = (qmark_left_q == 2'd1) && !last_pend_q;
		end else begin
			m_tdata = {run_q.count, run_q.unit};
			m_tuser = run_q.term;
			m_tlast = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/u2u_checker.sv -----
// Port-level checker for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on utf8_to_ucs2_decoder only through its ports.
`default_nettype none

module u2u_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	// a terminator always closes the run of its byte
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("terminator without tlast");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000)
		else $error("terminator with nonzero code unit");

	a_count_only_term: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'h0000)
		else $error("unit count on a non-terminator item");

	// only flushed '?' units can precede the final result of a run
	a_flush_qmark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[15:0] == 16'h003F)
		else $error("non-final item is not '?'");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("tvalid dropped while stalled");

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
